// File: hw/rtl/bfa_pkg.sv
// Shared constants, codes and types for the blob feature accumulator.
package bfa_pkg;

    // Fixed field geometry
    localparam int COORD_BITS     = 12;
    localparam int FRAC_BITS      = 8;
    localparam int CENTER_W       = COORD_BITS + FRAC_BITS;
    localparam int VAL_W          = 16;
    localparam int SCALE_W        = 16;
    localparam int VSUM_W         = 24;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int COUNT_OUT_W    = 9;
    localparam int MAX_PIXELS_DEF = 256;

    // Stream bus widths, padded to whole bytes
    localparam int IN_USED_W   = 2 * COORD_BITS + VAL_W + SCALE_W + 1;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W  = COUNT_OUT_W + 4 * COORD_BITS + 2 * VAL_W + VSUM_W
                                 + 2 * CENTER_W + 1;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK,
        S_MUL,
        S_QSEL,
        S_DLOAD,
        S_DIV,
        S_DONE
    } state_t;

endpackage

// File: hw/rtl/blob_feature_accumulator.sv
// Blob feature accumulator: pixel store, running moments and centroid divider.
//
//  channel  | direction | beat
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | one command item: append, clear or query
//  m_axis   | out       | one result item per command: status and statistics
//
// An append first runs the duplicate search, which reads the position memory one
// entry per cycle and is skipped for an empty store; then one shared multiplier
// forms the five moment products. A duplicate ends at its hit, and an append into
// a full store skips the products. A query runs one shared restoring divider that
// produces one quotient bit per cycle, 20 bits per axis. A new item is taken while
// the previous result still waits on m_axis; a finished item holds in its last
// cycle until that result leaves. Reset is asynchronous and clears the statistics;
// the position memory is not cleared and needs no clearing pass.
module blob_feature_accumulator #(
    parameter int MAX_PIXELS = bfa_pkg::MAX_PIXELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // x_bin, y_bin, pixel_value, pixel_scale, weight_by_value, zero pad
    input  logic [bfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [bfa_pkg::FUNC_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_count, x_min, x_max, y_min, y_max, value_low, value_high,
    // value_total, x_center, y_center, centroid_valid, zero pad
    output logic [bfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [bfa_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import bfa_pkg::*;

    localparam int G       = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int ADDR_W  = G;
    localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
    localparam int KEY_W   = 2 * COORD_BITS;
    localparam int SS_W    = SCALE_W + G;
    localparam int SXY_W   = SCALE_W + COORD_BITS + G;
    localparam int PSV_W   = SCALE_W + VAL_W;
    localparam int SV_W    = PSV_W + G;
    localparam int SVXY_W  = PSV_W + COORD_BITS + G;
    localparam int MA_W    = PSV_W + 1;
    localparam int MB_W    = ((VAL_W > COORD_BITS) ? VAL_W : COORD_BITS) + 1;
    localparam int P_W     = MA_W + MB_W;
    localparam int DEN_W   = SV_W;
    localparam int NUM_W   = SVXY_W;
    localparam int REM_W   = DEN_W + 1;
    localparam int QCNT_W  = $clog2(CENTER_W);
    localparam int STEP_W  = 3;
    localparam int X_LO    = 0;
    localparam int Y_LO    = COORD_BITS;
    localparam int V_LO    = 2 * COORD_BITS;
    localparam int S_LO    = V_LO + VAL_W;
    localparam int WV_BIT  = S_LO + SCALE_W;
    localparam int CV_BIT  = OUT_USED_W - 1;

    localparam logic [COORD_BITS-1:0] COORD_ALL = {COORD_BITS{1'b1}};
    localparam logic signed [VAL_W-1:0] VAL_TOP = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_BOT = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [CENTER_W-1:0] CENTER_MAX = {CENTER_W{1'b1}};

    // Sequencer and item registers
    state_t                   state_reg, state_next;
    func_t                    func_reg, func_next;
    logic [COORD_BITS-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [VAL_W-1:0]  v_reg, v_next;
    logic [SCALE_W-1:0]       s_reg, s_next;
    logic                     wv_reg, wv_next;

    // Blob statistics
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [COORD_BITS-1:0]    bxl_reg, bxl_next, bxh_reg, bxh_next;
    logic [COORD_BITS-1:0]    byl_reg, byl_next, byh_reg, byh_next;
    logic signed [VAL_W-1:0]  vlo_reg, vlo_next, vhi_reg, vhi_next;
    logic signed [VSUM_W-1:0] vsum_reg, vsum_next;
    logic [SS_W-1:0]          ss_reg, ss_next;
    logic [SXY_W-1:0]         sx_reg, sx_next, sy_reg, sy_next;
    logic signed [SV_W-1:0]   svs_reg, svs_next;
    logic signed [SVXY_W-1:0] svx_reg, svx_next, svy_reg, svy_next;

    // Search, multiply and divide datapath
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic [KEY_W-1:0]         rd_data_reg;
    logic                     mem_we;
    logic                     hit;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [P_W-1:0]    prod_reg, prod_next;
    logic signed [PSV_W-1:0]  sv_reg, sv_next;
    status_t                  status_reg, status_next;
    logic [CENTER_W-1:0]      xc_reg, xc_next, yc_reg, yc_next;
    logic                     cv_reg, cv_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic                     use_sv_reg, use_sv_next;
    logic                     axis_reg, axis_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic [CENTER_W-1:0]      nsh_reg, nsh_next;
    logic [CENTER_W-1:0]      q_reg, q_next;
    logic [QCNT_W-1:0]        qcnt_reg, qcnt_next;
    logic signed [NUM_W-1:0]  num_sel;
    logic [NUM_W-1:0]         num_u;
    logic [REM_W-1:0]         trial;
    logic                     trial_ge;
    logic [CENTER_W-1:0]      center_val;
    logic                     center_done;
    logic signed [VSUM_W:0]   vsum_wide;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [OUT_DATA_W-1:0]    out_data_reg, out_data_next;

    logic [KEY_W-1:0]         pos_mem [MAX_PIXELS];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // Compare the stored position read last cycle with the new pixel
    assign hit = cmp_valid_reg && (rd_data_reg == {x_reg, y_reg});

    // Shared multiplier operands, one product per step
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = MA_W'(s_reg);  mul_b = MB_W'(v_reg); end
            3'd1:    begin mul_a = MA_W'(s_reg);  mul_b = MB_W'(x_reg); end
            3'd2:    begin mul_a = MA_W'(s_reg);  mul_b = MB_W'(y_reg); end
            3'd3:    begin mul_a = MA_W'(sv_reg); mul_b = MB_W'(x_reg); end
            3'd4:    begin mul_a = MA_W'(sv_reg); mul_b = MB_W'(y_reg); end
            default: begin mul_a = '0;            mul_b = '0;           end
        endcase
    end

    // Select the centroid numerator for the current axis
    always_comb
    begin
        if (use_sv_reg)
            num_sel = axis_reg ? svy_reg : svx_reg;
        else
            num_sel = axis_reg ? NUM_W'(sy_reg) : NUM_W'(sx_reg);
        num_u = num_sel;
    end

    // One restoring divide step
    assign trial    = {rem_reg, nsh_reg[CENTER_W-1]};
    assign trial_ge = (trial >= REM_W'(den_reg));

    assign vsum_wide = (VSUM_W+1)'(vsum_reg) + (VSUM_W+1)'(v_reg);

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        v_next          = v_reg;
        s_next          = s_reg;
        wv_next         = wv_reg;
        count_next      = count_reg;
        bxl_next        = bxl_reg;
        bxh_next        = bxh_reg;
        byl_next        = byl_reg;
        byh_next        = byh_reg;
        vlo_next        = vlo_reg;
        vhi_next        = vhi_reg;
        vsum_next       = vsum_reg;
        ss_next         = ss_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        svs_next        = svs_reg;
        svx_next        = svx_reg;
        svy_next        = svy_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = 1'b0;
        mem_we          = 1'b0;
        step_next       = step_reg;
        prod_next       = mul_a * mul_b;
        sv_next         = sv_reg;
        status_next     = status_reg;
        xc_next         = xc_reg;
        yc_next         = yc_reg;
        cv_next         = cv_reg;
        den_next        = den_reg;
        use_sv_next     = use_sv_reg;
        axis_next       = axis_reg;
        rem_next        = rem_reg;
        nsh_next        = nsh_reg;
        q_next          = q_reg;
        qcnt_next       = qcnt_reg;
        center_val      = '0;
        center_done     = 1'b0;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next   = func_t'(s_axis_tuser);
                    x_next      = s_axis_tdata[X_LO +: COORD_BITS];
                    y_next      = s_axis_tdata[Y_LO +: COORD_BITS];
                    v_next      = s_axis_tdata[V_LO +: VAL_W];
                    s_next      = s_axis_tdata[S_LO +: SCALE_W];
                    wv_next     = s_axis_tdata[WV_BIT];
                    status_next = ST_OK;
                    xc_next     = '0;
                    yc_next     = '0;
                    cv_next     = 1'b0;
                    idx_next    = '0;
                    case (func_t'(s_axis_tuser))
                        FUNC_APPEND:
                            state_next = (count_reg == '0) ? S_CHECK : S_SEARCH;
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            bxl_next   = COORD_ALL;
                            bxh_next   = '0;
                            byl_next   = COORD_ALL;
                            byh_next   = '0;
                            vlo_next   = VAL_TOP;
                            vhi_next   = VAL_BOT;
                            vsum_next  = '0;
                            ss_next    = '0;
                            sx_next    = '0;
                            sy_next    = '0;
                            svs_next   = '0;
                            svx_next   = '0;
                            svy_next   = '0;
                            state_next = S_DONE;
                        end
                        FUNC_QUERY:
                            state_next = S_QSEL;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            // Walk the stored positions, one read per cycle
            S_SEARCH:
            begin
                if (hit)
                begin
                    status_next = ST_DUP;
                    state_next  = S_DONE;
                end
                else if ((idx_reg == count_reg) && !cmp_valid_reg)
                begin
                    state_next = S_CHECK;
                end
                else if (idx_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                end
            end

            // Flag a full store, else store the pixel and update box, extremes and plain sums
            S_CHECK:
            begin
                if (count_reg >= CNT_W'(MAX_PIXELS))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (x_reg < bxl_reg) bxl_next = x_reg;
                    if (x_reg > bxh_reg) bxh_next = x_reg;
                    if (y_reg < byl_reg) byl_next = y_reg;
                    if (y_reg > byh_reg) byh_next = y_reg;
                    if (v_reg < vlo_reg) vlo_next = v_reg;
                    if (v_reg > vhi_reg) vhi_next = v_reg;
                    if (vsum_wide[VSUM_W] != vsum_wide[VSUM_W-1])
                        vsum_next = vsum_wide[VSUM_W] ? {1'b1, {(VSUM_W-1){1'b0}}}
                                                      : {1'b0, {(VSUM_W-1){1'b1}}};
                    else
                        vsum_next = vsum_wide[VSUM_W-1:0];
                    ss_next    = ss_reg + SS_W'(s_reg);
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end

            // Issue one product per step, accumulate the previous one
            S_MUL:
            begin
                case (step_reg)
                    3'd1:
                    begin
                        svs_next = svs_reg + SV_W'(prod_reg);
                        sv_next  = prod_reg[PSV_W-1:0];
                    end
                    3'd2:    sx_next  = sx_reg + SXY_W'(prod_reg);
                    3'd3:    sy_next  = sy_reg + SXY_W'(prod_reg);
                    3'd4:    svx_next = svx_reg + SVXY_W'(prod_reg);
                    3'd5:    svy_next = svy_reg + SVXY_W'(prod_reg);
                    default: ;
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd5)
                    state_next = S_DONE;
            end

            // Pick the weight sum, fall back to scale only, else report no centroid
            S_QSEL:
            begin
                axis_next = 1'b0;
                if (wv_reg && !svs_reg[SV_W-1] && (svs_reg != '0))
                begin
                    den_next    = svs_reg;
                    use_sv_next = 1'b1;
                    cv_next     = 1'b1;
                    state_next  = S_DLOAD;
                end
                else if (ss_reg != '0)
                begin
                    den_next    = DEN_W'(ss_reg);
                    use_sv_next = 1'b0;
                    cv_next     = 1'b1;
                    state_next  = S_DLOAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Handle non-positive and saturating numerators, else seed divider
            S_DLOAD:
            begin
                if (num_sel[NUM_W-1] || (num_sel == '0))
                begin
                    center_val  = '0;
                    center_done = 1'b1;
                end
                else if (num_u >= {den_reg, COORD_BITS'(0)})
                begin
                    center_val  = CENTER_MAX;
                    center_done = 1'b1;
                end
                else
                begin
                    rem_next   = DEN_W'(num_u >> COORD_BITS);
                    nsh_next   = {num_u[COORD_BITS-1:0], FRAC_BITS'(0)};
                    q_next     = '0;
                    qcnt_next  = QCNT_W'(CENTER_W - 1);
                    state_next = S_DIV;
                end
            end

            // One quotient bit per cycle
            S_DIV:
            begin
                rem_next  = trial_ge ? DEN_W'(trial - REM_W'(den_reg)) : DEN_W'(trial);
                nsh_next  = {nsh_reg[CENTER_W-2:0], 1'b0};
                q_next    = {q_reg[CENTER_W-2:0], trial_ge};
                qcnt_next = qcnt_reg - 1'b1;
                if (qcnt_reg == '0)
                begin
                    center_val  = {q_reg[CENTER_W-2:0], trial_ge};
                    center_done = 1'b1;
                end
            end

            // Hand the result to the output register when it is free
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = {(OUT_DATA_W - OUT_USED_W)'(0), cv_reg, yc_reg, xc_reg,
                                       vsum_reg, vhi_reg, vlo_reg, byh_reg, byl_reg,
                                       bxh_reg, bxl_reg, COUNT_OUT_W'(count_reg)};
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        // Store a finished axis and move on
        if (center_done)
        begin
            if (axis_reg)
            begin
                yc_next    = center_val;
                state_next = S_DONE;
            end
            else
            begin
                xc_next    = center_val;
                axis_next  = 1'b1;
                state_next = S_DLOAD;
            end
        end
    end

    // Control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            bxl_reg       <= COORD_ALL;
            bxh_reg       <= '0;
            byl_reg       <= COORD_ALL;
            byh_reg       <= '0;
            vlo_reg       <= VAL_TOP;
            vhi_reg       <= VAL_BOT;
            vsum_reg      <= '0;
            ss_reg        <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            svs_reg       <= '0;
            svx_reg       <= '0;
            svy_reg       <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            qcnt_reg      <= '0;
            axis_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            bxl_reg       <= bxl_next;
            bxh_reg       <= bxh_next;
            byl_reg       <= byl_next;
            byh_reg       <= byh_next;
            vlo_reg       <= vlo_next;
            vhi_reg       <= vhi_next;
            vsum_reg      <= vsum_next;
            ss_reg        <= ss_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            svs_reg       <= svs_next;
            svx_reg       <= svx_next;
            svy_reg       <= svy_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            qcnt_reg      <= qcnt_next;
            axis_reg      <= axis_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        v_reg          <= v_next;
        s_reg          <= s_next;
        wv_reg         <= wv_next;
        prod_reg       <= prod_next;
        sv_reg         <= sv_next;
        status_reg     <= status_next;
        xc_reg         <= xc_next;
        yc_reg         <= yc_next;
        cv_reg         <= cv_next;
        den_reg        <= den_next;
        use_sv_reg     <= use_sv_next;
        rem_reg        <= rem_next;
        nsh_reg        <= nsh_next;
        q_reg          <= q_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    // Position memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pos_mem[count_reg[ADDR_W-1:0]] <= {x_reg, y_reg};
        rd_data_reg <= pos_mem[idx_reg[ADDR_W-1:0]];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count exceeds store depth");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (idx_reg <= count_reg))
        else $error("search index ran past the fill count");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while previous item still in work");

    a_centroid_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[CV_BIT]) |-> (m_axis_tuser == ST_OK))
        else $error("valid centroid reported with non-ok status");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking bench for the blob feature accumulator with a built-in predictor.
`timescale 1ns / 100ps

module testbench;

    import bfa_pkg::*;

    localparam int     HELD_MAX   = MAX_PIXELS_DEF;
    localparam longint CENTER_MAX = (longint'(1) << CENTER_W) - 1;
    localparam int     VSUM_HI    = 8388607;
    localparam int     VSUM_LO    = -8388608;
    localparam int     LIMIT      = 600000;
    localparam int     COORD_TOP  = (1 << COORD_BITS) - 1;

    // Command item, lowest field in the lowest bits
    typedef struct packed {
        logic [IN_DATA_W-IN_USED_W-1:0] pad;
        logic                           weight_by_value;
        logic [SCALE_W-1:0]             pixel_scale;
        logic signed [VAL_W-1:0]        pixel_value;
        logic [COORD_BITS-1:0]          y_bin;
        logic [COORD_BITS-1:0]          x_bin;
    } pixel_cmd_t;

    // Statistics item, lowest field in the lowest bits
    typedef struct packed {
        logic [OUT_DATA_W-OUT_USED_W-1:0] pad;
        logic                             centroid_valid;
        logic [CENTER_W-1:0]              y_center;
        logic [CENTER_W-1:0]              x_center;
        logic signed [VSUM_W-1:0]         value_total;
        logic signed [VAL_W-1:0]          value_high;
        logic signed [VAL_W-1:0]          value_low;
        logic [COORD_BITS-1:0]            y_max;
        logic [COORD_BITS-1:0]            y_min;
        logic [COORD_BITS-1:0]            x_max;
        logic [COORD_BITS-1:0]            x_min;
        logic [COUNT_OUT_W-1:0]           pixel_count;
    } blob_stats_t;

    typedef struct packed {
        status_t     status;
        blob_stats_t stats;
    } blob_result_t;

    typedef struct packed {
        bit         wait_idle;
        func_t      func;
        pixel_cmd_t cmd;
    } queued_cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [FUNC_W-1:0]     s_axis_tuser = FUNC_NOP;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // Stimulus and scoreboard
    queued_cmd_t  cmd_backlog[$];
    blob_result_t owed_results[$];
    queued_cmd_t  cur_cmd;
    blob_result_t want;
    blob_stats_t  got;
    bit           idle_next = 1'b0;
    logic         calm = 1'b0;
    int           send_gap = 0;
    int           recv_stall = 0;
    int           long_hold = 0;
    bit           long_hold_done = 1'b0;
    int           results_seen = 0;
    int           errors = 0;
    int           cycles = 0;

    // Predicted blob state
    logic [2*COORD_BITS-1:0] held_keys[$];
    int     box_xl, box_xh, box_yl, box_yh;
    int     vlow, vhigh, vsum;
    longint s_sum, sx_sum, sy_sum, sv_sum, svx_sum, svy_sum;

    // Coverage tallies
    int n_append = 0, n_dup = 0, n_full = 0, n_clear = 0, n_query = 0;
    int n_weighted = 0, n_fallback = 0, n_no_centroid = 0;

    blob_feature_accumulator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Empty blob
    function automatic void clear_blob();
        held_keys.delete();
        box_xl = COORD_TOP;
        box_xh = 0;
        box_yl = COORD_TOP;
        box_yh = 0;
        vlow = 32767;
        vhigh = -32768;
        vsum = 0;
        s_sum = 0;
        sx_sum = 0;
        sy_sum = 0;
        sv_sum = 0;
        svx_sum = 0;
        svy_sum = 0;
    endfunction

    // floor(256 * num / den), zero when either is not positive, saturated
    function automatic logic [CENTER_W-1:0] centroid_q8(longint num, longint den);
        longint q_int, rem, q;
        if (num <= 0 || den <= 0)
            return '0;
        q_int = num / den;
        rem = num % den;
        if (q_int > (CENTER_MAX >> 8))
            return CENTER_MAX[CENTER_W-1:0];
        q = (q_int << 8) + (rem << 8) / den;
        if (q > CENTER_MAX)
            q = CENTER_MAX;
        return q[CENTER_W-1:0];
    endfunction

    // Apply one command to the predicted blob and return the statistics it owes
    function automatic blob_result_t blob_update(func_t op, pixel_cmd_t c);
        blob_result_t r;
        logic [2*COORD_BITS-1:0] key;
        bit     seen;
        int     x, y, v, ns;
        longint sc, sv;
        r = '0;
        r.status = ST_OK;
        key = {c.x_bin, c.y_bin};
        x = int'(c.x_bin);
        y = int'(c.y_bin);
        v = int'(c.pixel_value);
        sc = longint'(c.pixel_scale);
        case (op)
            FUNC_APPEND:
            begin
                n_append++;
                seen = 1'b0;
                foreach (held_keys[i])
                    if (held_keys[i] == key)
                        seen = 1'b1;
                if (seen)
                begin
                    r.status = ST_DUP;
                    n_dup++;
                end
                else if (held_keys.size() >= HELD_MAX)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    held_keys.insert(held_keys.size(), key);
                    if (x < box_xl) box_xl = x;
                    if (x > box_xh) box_xh = x;
                    if (y < box_yl) box_yl = y;
                    if (y > box_yh) box_yh = y;
                    if (v < vlow) vlow = v;
                    if (v > vhigh) vhigh = v;
                    ns = vsum + v;
                    if (ns > VSUM_HI) ns = VSUM_HI;
                    if (ns < VSUM_LO) ns = VSUM_LO;
                    vsum = ns;
                    sv = sc * v;
                    s_sum += sc;
                    sx_sum += sc * x;
                    sy_sum += sc * y;
                    sv_sum += sv;
                    svx_sum += sv * x;
                    svy_sum += sv * y;
                end
            end
            FUNC_CLEAR:
            begin
                n_clear++;
                clear_blob();
            end
            FUNC_QUERY:
            begin
                n_query++;
                // weight by scale*value when asked and possible, else by scale alone
                if (c.weight_by_value && sv_sum > 0)
                begin
                    r.stats.x_center = centroid_q8(svx_sum, sv_sum);
                    r.stats.y_center = centroid_q8(svy_sum, sv_sum);
                    r.stats.centroid_valid = 1'b1;
                    n_weighted++;
                end
                else
                begin
                    if (c.weight_by_value)
                        n_fallback++;
                    if (s_sum > 0)
                    begin
                        r.stats.x_center = centroid_q8(sx_sum, s_sum);
                        r.stats.y_center = centroid_q8(sy_sum, s_sum);
                        r.stats.centroid_valid = 1'b1;
                    end
                    else
                        n_no_centroid++;
                end
            end
            default: ;
        endcase
        r.stats.pixel_count = COUNT_OUT_W'(held_keys.size());
        r.stats.x_min = COORD_BITS'(box_xl);
        r.stats.x_max = COORD_BITS'(box_xh);
        r.stats.y_min = COORD_BITS'(box_yl);
        r.stats.y_max = COORD_BITS'(box_yh);
        r.stats.value_low = VAL_W'(vlow);
        r.stats.value_high = VAL_W'(vhigh);
        r.stats.value_total = VSUM_W'(vsum);
        return r;
    endfunction

    function automatic void check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    // Stimulus helpers
    task automatic queue_cmd(func_t op, int x, int y, int v, int s, bit wv);
        queued_cmd_t it;
        it = '0;
        it.wait_idle = idle_next;
        it.func = op;
        it.cmd.x_bin = x[COORD_BITS-1:0];
        it.cmd.y_bin = y[COORD_BITS-1:0];
        it.cmd.pixel_value = v[VAL_W-1:0];
        it.cmd.pixel_scale = s[SCALE_W-1:0];
        it.cmd.weight_by_value = wv;
        idle_next = 1'b0;
        cmd_backlog.insert(cmd_backlog.size(), it);
    endtask

    function automatic int rand_value();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 512) - 256;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    function automatic int rand_scale();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 255);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Any command with any content
    task automatic queue_noise(func_t op);
        queue_cmd(op, $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP),
                  rand_value(), rand_scale(), $urandom_range(0, 1));
    endtask

    // Clear, then appends in a small window so positions repeat, with queries and random commands between
    task automatic queue_blob(int n_app);
        int span, bx, by, k;
        span = $urandom_range(1, 40);
        bx = $urandom_range(0, COORD_TOP - span);
        by = $urandom_range(0, COORD_TOP - span);
        queue_noise(FUNC_CLEAR);
        for (k = 0; k < n_app; k++)
        begin
            queue_cmd(FUNC_APPEND, bx + $urandom_range(0, span), by + $urandom_range(0, span),
                      rand_value(), rand_scale(), $urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0)
                queue_noise(FUNC_QUERY);
            if ($urandom_range(0, 15) == 0)
                queue_noise(func_t'($urandom_range(0, 3)));
        end
        queue_noise(FUNC_QUERY);
    endtask

    // Fill the store to the top, then push past it
    task automatic queue_full_blob();
        int bx, by, k, j;
        bx = $urandom_range(0, COORD_TOP - 16);
        by = $urandom_range(0, COORD_TOP - 17);
        queue_noise(FUNC_CLEAR);
        for (k = 0; k < HELD_MAX + 4; k++)
        begin
            queue_cmd(FUNC_APPEND, bx + k % 16, by + k / 16, 32767, rand_scale(),
                      $urandom_range(0, 1));
            if (k > 0 && $urandom_range(0, 19) == 0)
            begin
                j = $urandom_range(0, k - 1);
                queue_cmd(FUNC_APPEND, bx + j % 16, by + j / 16, rand_value(), rand_scale(),
                          $urandom_range(0, 1));
            end
            if ($urandom_range(0, 39) == 0)
                queue_noise(FUNC_QUERY);
        end
        // duplicate wins over full
        queue_cmd(FUNC_APPEND, bx, by, rand_value(), rand_scale(), 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b1);
    endtask

    // Offer backlog items, record what each accepted item owes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= FUNC_NOP;
            send_gap <= 0;
            calm <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                owed_results.insert(owed_results.size(),
                                    blob_update(func_t'(s_axis_tuser),
                                                pixel_cmd_t'(s_axis_tdata)));
            calm <= (cmd_backlog.size() < 40);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].wait_idle && owed_results.size() != 0))
                begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_axis_tdata <= cur_cmd.cmd;
                    s_axis_tuser <= cur_cmd.func;
                    s_axis_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 6);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Take results, compare with the oldest owed one, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall <= 0;
            long_hold <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got = blob_stats_t'(m_axis_tdata);
                if (owed_results.size() == 0)
                begin
                    $error("result item arrived with none outstanding");
                    errors++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("pixel_count", want.stats.pixel_count, got.pixel_count);
                    check_field("x_min", want.stats.x_min, got.x_min);
                    check_field("x_max", want.stats.x_max, got.x_max);
                    check_field("y_min", want.stats.y_min, got.y_min);
                    check_field("y_max", want.stats.y_max, got.y_max);
                    check_field("value_low", want.stats.value_low, got.value_low);
                    check_field("value_high", want.stats.value_high, got.value_high);
                    check_field("value_total", want.stats.value_total, got.value_total);
                    check_field("x_center", want.stats.x_center, got.x_center);
                    check_field("y_center", want.stats.y_center, got.y_center);
                    check_field("centroid_valid", want.stats.centroid_valid,
                                got.centroid_valid);
                end
            end
            // one long hold-off so the block backs up into its input
            if (long_hold != 0)
            begin
                m_axis_tready <= 1'b0;
                long_hold <= long_hold - 1;
            end
            else if (!long_hold_done && results_seen >= 80)
            begin
                m_axis_tready <= 1'b0;
                long_hold <= 300;
                long_hold_done <= 1'b1;
            end
            else if (recv_stall != 0)
            begin
                m_axis_tready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                recv_stall <= $urandom_range(0, 5);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Guard against a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        clear_blob();

        // Directed: empty queries, unused code, extremes, duplicate, fallbacks
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b0);
        queue_cmd(FUNC_QUERY, COORD_TOP, COORD_TOP, 32767, 65535, 1'b1);
        queue_cmd(FUNC_NOP, COORD_TOP, 0, -32768, 65535, 1'b1);
        queue_cmd(FUNC_APPEND, 0, 0, -32768, 0, 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b0);
        queue_cmd(FUNC_APPEND, COORD_TOP, COORD_TOP, 32767, 65535, 1'b1);
        queue_cmd(FUNC_APPEND, 0, 0, 100, 500, 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b1);
        queue_cmd(FUNC_APPEND, COORD_TOP, 0, -32768, 65535, 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b1);
        queue_cmd(FUNC_APPEND, 0, COORD_TOP, 1, 1, 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b1);
        queue_cmd(FUNC_CLEAR, COORD_TOP, COORD_TOP, -1, 65535, 1'b1);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b1);
        // value weights of mixed sign: centroid far outside the box saturates
        queue_cmd(FUNC_APPEND, 4000, 4000, 300, 256, 1'b0);
        queue_cmd(FUNC_APPEND, 100, 100, -256, 256, 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b1);
        queue_cmd(FUNC_CLEAR, 0, 0, 0, 0, 1'b0);
        // negative moment on one axis clamps to zero
        queue_cmd(FUNC_APPEND, 4000, 10, -256, 256, 1'b0);
        queue_cmd(FUNC_APPEND, 100, 200, 300, 256, 1'b0);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b1);
        queue_cmd(FUNC_QUERY, 0, 0, 0, 0, 1'b0);

        // Random blobs, the full store, more random blobs
        idle_next = 1'b1;
        while (cmd_backlog.size() < 60)
            queue_blob($urandom_range(1, 30));
        idle_next = 1'b1;
        queue_full_blob();
        while (cmd_backlog.size() < 400)
            queue_blob($urandom_range(1, 30));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // drain
        while (cmd_backlog.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Ran %0d appends (%0d duplicates, %0d into a full store),",
                 n_append, n_dup, n_full);
        $display("%0d clears, %0d queries: %0d value-weighted, %0d fell back, %0d empty",
                 n_clear, n_query, n_weighted, n_fallback, n_no_centroid);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bfa_pkg.sv
hw/rtl/blob_feature_accumulator.sv
verif/testbench.sv
